// File: rtl/yrgb_pkg.sv
// ============================================================================
// yrgb_pkg
// Shared types, constants and helper functions for the YUYV to RGB raster
// block.
// ============================================================================
package yrgb_pkg;

    localparam int SIDE_MAX  = 4096;
    localparam int POS_W     = 12;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 25;
    localparam int SUM_W     = 26;

    // Q2.14 full-range coefficients
    localparam logic signed [15:0] K_B_C1 = 16'sd22970;
    localparam logic signed [15:0] K_G_C2 = 16'sd5638;
    localparam logic signed [15:0] K_G_C1 = 16'sd11700;
    localparam logic signed [15:0] K_R_C2 = 16'sd29032;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd160;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_COLOUR_MODE  = 2'd2
    } cfg_idx_t;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [POS_W-1:0]  pos_idx_t;
    typedef logic signed [PROD_W-1:0] prod_val_t;

    typedef struct packed {
        pos_idx_t row;
        pos_idx_t col;
    } pos_t;

    typedef struct packed {
        byte_t red;
        byte_t green;
        byte_t blue;
    } rgb_t;

    // Pair of pixels waiting for the multipliers
    typedef struct packed {
        byte_t y0;
        byte_t y1;
        byte_t c1;
        byte_t c2;
        logic  grey;
        logic  two;
        pos_t  pos_a;
        logic  done_a;
        pos_t  pos_b;
        logic  done_b;
    } job_t;

    // Chroma products shared by both pixels of a pair
    typedef struct packed {
        byte_t     y0;
        byte_t     y1;
        logic      grey;
        logic      two;
        prod_val_t pb;
        prod_val_t pr;
        prod_val_t pg1;
        prod_val_t pg2;
        pos_t      pos_a;
        logic      done_a;
        pos_t      pos_b;
        logic      done_b;
    } prod_t;

    typedef struct packed {
        rgb_t  rgb;
        pos_t  pos;
        logic  last;
        logic  done;
    } pixel_t;

    // Last valid index of a side: zero reads as one, oversize saturates
    function automatic pos_idx_t last_index(input logic [CFG_W-1:0] v);
        pos_idx_t r;
        if (v == '0)
            r = '0;
        else if (v > CFG_W'(SIDE_MAX))
            r = POS_W'(SIDE_MAX - 1);
        else
            r = POS_W'(v - CFG_W'(1));
        return r;
    endfunction

    function automatic pos_t advance(input pos_t p, input pos_idx_t col_last);
        pos_t r;
        if (p.col >= col_last)
        begin
            r.col = '0;
            r.row = p.row + POS_W'(1);
        end
        else
        begin
            r.col = p.col + POS_W'(1);
            r.row = p.row;
        end
        return r;
    endfunction

    // Floor of a Q.14 value, clamped to 0..255
    function automatic byte_t q14_to_byte(input logic [SUM_W-1:0] q);
        byte_t r;
        if (q[SUM_W-1])
            r = '0;
        else if (|q[SUM_W-2:22])
            r = '1;
        else
            r = q[21:14];
        return r;
    endfunction

    function automatic rgb_t colour_of(input byte_t y, input prod_val_t pb,
                                       input prod_val_t pr, input prod_val_t pg1,
                                       input prod_val_t pg2);
        logic [SUM_W-1:0] yy;
        logic [SUM_W-1:0] b_q;
        logic [SUM_W-1:0] g_q;
        logic [SUM_W-1:0] r_q;
        rgb_t             r;
        yy      = {4'b0, y, 14'b0};
        b_q     = yy + {pb[PROD_W-1], pb};
        g_q     = yy - {pg2[PROD_W-1], pg2} - {pg1[PROD_W-1], pg1};
        r_q     = yy + {pr[PROD_W-1], pr};
        r.blue  = q14_to_byte(b_q);
        r.green = q14_to_byte(g_q);
        r.red   = q14_to_byte(r_q);
        return r;
    endfunction

endpackage

// File: rtl/yrgb_if.sv
// ============================================================================
// yrgb_if
// Valid/ready channel interfaces: camera byte input and pixel output.
// ============================================================================
interface yrgb_in_if;
    logic                         valid;
    logic                         ready;
    logic [yrgb_pkg::BYTE_W-1:0]  component;
    logic                         frame_start;

    modport source (output valid, output component, output frame_start, input ready);
    modport sink   (input valid, input component, input frame_start, output ready);
endinterface

interface yrgb_out_if;
    logic                         valid;
    logic                         ready;
    logic [yrgb_pkg::BYTE_W-1:0]  red;
    logic [yrgb_pkg::BYTE_W-1:0]  green;
    logic [yrgb_pkg::BYTE_W-1:0]  blue;
    logic [yrgb_pkg::POS_W-1:0]   pixel_row;
    logic [yrgb_pkg::POS_W-1:0]   pixel_col;
    logic                         last_of_run;
    logic                         frame_done;

    modport source (output valid, output red, output green, output blue,
                    output pixel_row, output pixel_col, output last_of_run,
                    output frame_done, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input pixel_row, input pixel_col, input last_of_run,
                    input frame_done, output ready);
endinterface

// File: rtl/yuyv_stream_to_rgb_raster_top.sv
// ============================================================================
// yuyv_stream_to_rgb_raster_top
// YUYV (or grey) camera byte stream to RGB pixels with raster positions.
// ============================================================================
//  channel  | dir | payload                                        | size
//  ---------+-----+------------------------------------------------+---------
//  camera   | in  | component, frame_start                         | 1 byte
//  raster   | out | red, green, blue, pixel_row, pixel_col,        | 1 pixel
//           |     | last_of_run, frame_done                        |
//  cfg      | in  | cfg_we, cfg_index, cfg_data                    | 1 reg
//
//  One byte accepted per cycle while camera.ready is high. Grey mode: one
//  pixel per byte; colour mode: two pixels per four-byte group. Pixels pass
//  the byte stage, multiplier stage and output register pair in turn.
//  Reset: frame closed, 160x120, colour mode; waits for frame_start.
//  camera.ready drops only when raster back-pressure fills all three stages.
// ============================================================================
module yuyv_stream_to_rgb_raster_top
(
    input  logic                             clk,
    input  logic                             rst_n,
    yrgb_in_if.sink                          camera,
    yrgb_out_if.source                       raster,
    input  logic                             cfg_we,
    input  logic [yrgb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yrgb_pkg::CFG_W-1:0]       cfg_data
);
    import yrgb_pkg::*;

    typedef enum logic [1:0] {
        PH_Y0 = 2'd0,
        PH_C1 = 2'd1,
        PH_Y1 = 2'd2,
        PH_C2 = 2'd3
    } phase_t;

    // configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             colour_reg;

    // position and phase state
    pos_t   pos_reg,    pos_next;
    phase_t phase_reg,  phase_next;
    logic   open_reg,   open_next;
    byte_t  y0_reg,     y0_next;
    byte_t  c1_reg,     c1_next;
    byte_t  y1_reg,     y1_next;

    // pipeline
    logic   s1_valid_reg;
    job_t   s1_reg;
    logic   s2_valid_reg;
    prod_t  s2_reg;
    logic [1:0] cnt_reg,   cnt_next;
    pixel_t slot0_reg,     slot0_next;
    pixel_t slot1_reg,     slot1_next;

    logic     in_fire;
    logic     out_fire;
    logic     s1_ready;
    logic     s2_ready;
    logic     s3_take;
    pos_idx_t col_last;
    pos_idx_t row_last;
    pos_t     eff_pos;
    phase_t   eff_phase;
    logic     eff_open;
    logic     grey;
    logic     produce;
    pos_t     pos_a1;
    pos_t     pos_b1;
    logic     done_a;
    logic     done_b;
    job_t     job;
    logic signed [8:0] d1;
    logic signed [8:0] d2;
    rgb_t     rgb_a;
    rgb_t     rgb_b;
    pixel_t   pix_a;
    pixel_t   pix_b;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
            colour_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_COLOUR_MODE:  colour_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    assign out_fire      = raster.valid & raster.ready;
    assign s3_take       = s2_valid_reg &&
                           ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && raster.ready));
    assign s2_ready      = !s2_valid_reg || s3_take;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign camera.ready  = s1_ready;
    assign in_fire       = camera.valid & s1_ready;

    // ---------------- byte stage ----------------
    assign col_last  = last_index(width_reg);
    assign row_last  = last_index(height_reg);
    assign grey      = !colour_reg;
    assign eff_pos   = camera.frame_start ? '0 : pos_reg;
    assign eff_phase = camera.frame_start ? PH_Y0 : phase_reg;
    assign eff_open  = camera.frame_start | open_reg;
    assign produce   = eff_open && (grey || (eff_phase == PH_C2));
    assign done_a    = (eff_pos.row >= row_last) && (eff_pos.col >= col_last);
    assign pos_a1    = advance(eff_pos, col_last);
    assign done_b    = (pos_a1.row >= row_last) && (pos_a1.col >= col_last);
    assign pos_b1    = advance(pos_a1, col_last);

    always_comb
    begin
        job.y0     = grey ? camera.component : y0_reg;
        job.y1     = y1_reg;
        job.c1     = c1_reg;
        job.c2     = camera.component;
        job.grey   = grey;
        job.two    = !grey && !done_a;
        job.pos_a  = eff_pos;
        job.done_a = done_a;
        job.pos_b  = pos_a1;
        job.done_b = done_b;
    end

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        open_next  = open_reg;
        y0_next    = y0_reg;
        c1_next    = c1_reg;
        y1_next    = y1_reg;
        if (in_fire)
        begin
            pos_next   = eff_pos;
            phase_next = eff_phase;
            open_next  = eff_open;
            if (eff_open)
            begin
                if (grey)
                begin
                    phase_next = PH_Y0;
                    if (done_a)
                        open_next = 1'b0;
                    else
                        pos_next = pos_a1;
                end
                else
                begin
                    case (eff_phase)
                        PH_Y0:
                        begin
                            y0_next    = camera.component;
                            phase_next = PH_C1;
                        end
                        PH_C1:
                        begin
                            c1_next    = camera.component;
                            phase_next = PH_Y1;
                        end
                        PH_Y1:
                        begin
                            y1_next    = camera.component;
                            phase_next = PH_C2;
                        end
                        PH_C2:
                        begin
                            phase_next = PH_Y0;
                            if (done_a)
                                open_next = 1'b0;
                            else if (done_b)
                            begin
                                pos_next  = pos_a1;
                                open_next = 1'b0;
                            end
                            else
                                pos_next = pos_b1;
                        end
                        default: phase_next = PH_Y0;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= PH_Y0;
            open_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y0_reg <= y0_next;
        c1_reg <= c1_next;
        y1_reg <= y1_next;
    end

    // ---------------- job register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_fire && produce;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_fire && produce)
            s1_reg <= job;
    end

    // ---------------- multiplier stage ----------------
    assign d1 = $signed({1'b0, s1_reg.c1}) - 9'sd128;
    assign d2 = $signed({1'b0, s1_reg.c2}) - 9'sd128;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg.y0     <= s1_reg.y0;
            s2_reg.y1     <= s1_reg.y1;
            s2_reg.grey   <= s1_reg.grey;
            s2_reg.two    <= s1_reg.two;
            s2_reg.pb     <= K_B_C1 * d1;
            s2_reg.pr     <= K_R_C2 * d2;
            s2_reg.pg1    <= K_G_C1 * d1;
            s2_reg.pg2    <= K_G_C2 * d2;
            s2_reg.pos_a  <= s1_reg.pos_a;
            s2_reg.done_a <= s1_reg.done_a;
            s2_reg.pos_b  <= s1_reg.pos_b;
            s2_reg.done_b <= s1_reg.done_b;
        end
    end

    // ---------------- sum, clamp and output pair ----------------
    assign rgb_a = s2_reg.grey ? rgb_t'{red: s2_reg.y0, green: s2_reg.y0, blue: s2_reg.y0}
                               : colour_of(s2_reg.y0, s2_reg.pb, s2_reg.pr,
                                           s2_reg.pg1, s2_reg.pg2);
    assign rgb_b = colour_of(s2_reg.y1, s2_reg.pb, s2_reg.pr, s2_reg.pg1, s2_reg.pg2);

    always_comb
    begin
        pix_a.rgb  = rgb_a;
        pix_a.pos  = s2_reg.pos_a;
        pix_a.last = !s2_reg.two;
        pix_a.done = s2_reg.done_a;
        pix_b.rgb  = rgb_b;
        pix_b.pos  = s2_reg.pos_b;
        pix_b.last = 1'b1;
        pix_b.done = s2_reg.done_b;
    end

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (out_fire)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (s3_take)
        begin
            slot0_next = pix_a;
            slot1_next = pix_b;
            cnt_next   = s2_reg.two ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign raster.valid       = (cnt_reg != 2'd0);
    assign raster.red         = slot0_reg.rgb.red;
    assign raster.green       = slot0_reg.rgb.green;
    assign raster.blue        = slot0_reg.rgb.blue;
    assign raster.pixel_row   = slot0_reg.pos.row;
    assign raster.pixel_col   = slot0_reg.pos.col;
    assign raster.last_of_run = slot0_reg.last;
    assign raster.frame_done  = slot0_reg.done;

endmodule

// File: rtl/yrgb_checker.sv
// ============================================================================
// yrgb_checker
// Port-level checks on the pixel output of the YUYV to RGB raster block.
// ============================================================================
module yrgb_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [yrgb_pkg::BYTE_W-1:0]   red,
    input logic [yrgb_pkg::BYTE_W-1:0]   green,
    input logic [yrgb_pkg::BYTE_W-1:0]   blue,
    input logic [yrgb_pkg::POS_W-1:0]    pixel_row,
    input logic [yrgb_pkg::POS_W-1:0]    pixel_col,
    input logic                          last_of_run,
    input logic                          frame_done
);

    // stalled transaction stays up
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("pixel valid dropped while stalled");

    // stalled transaction keeps its payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue)
            && $stable(pixel_row) && $stable(pixel_col) && $stable(last_of_run)
            && $stable(frame_done))
        else $error("pixel payload changed while stalled");

    // frame end always closes the run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame_done without last_of_run");

    // second pixel of a pair is ready right behind the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
        else $error("second pixel of pair missing");

endmodule

bind yuyv_stream_to_rgb_raster_top yrgb_checker u_yrgb_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (raster.valid),
    .out_ready   (raster.ready),
    .red         (raster.red),
    .green       (raster.green),
    .blue        (raster.blue),
    .pixel_row   (raster.pixel_row),
    .pixel_col   (raster.pixel_col),
    .last_of_run (raster.last_of_run),
    .frame_done  (raster.frame_done)
);

// File: bench/yuyv_stream_to_rgb_raster_checker.sv
// ============================================================================
// yuyv_stream_to_rgb_raster_checker
// Watches the camera, raster and config ports of the YUYV to RGB block.
// Keeps its own copy of the raster position, byte phase and frame state.
// Predicts every pixel from the accepted camera bytes and compares each
// raster transaction, field by field, with the oldest predicted pixel.
// ============================================================================
module yuyv_stream_to_rgb_raster_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    yrgb_in_if                              camera,
    yrgb_out_if                             raster,
    input  logic                            cfg_we,
    input  logic [yrgb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [yrgb_pkg::CFG_W-1:0]      cfg_data,
    output int unsigned                     fail_count,
    output int unsigned                     pixels_pending,
    output int unsigned                     pixels_checked,
    output int unsigned                     frames_closed
);
    import yrgb_pkg::*;

    // Q2.14 full-range coefficients
    localparam int COEF_B_C1 = 22970;
    localparam int COEF_G_C2 = 5638;
    localparam int COEF_G_C1 = 11700;
    localparam int COEF_R_C2 = 29032;

    typedef enum logic [1:0] {
        AWAIT_Y0 = 2'd0,
        AWAIT_C1 = 2'd1,
        AWAIT_Y1 = 2'd2,
        AWAIT_C2 = 2'd3
    } group_phase_t;

    typedef struct packed {
        byte_t    red;
        byte_t    green;
        byte_t    blue;
        pos_idx_t row;
        pos_idx_t col;
        logic     last;
        logic     done;
    } pixel_exp_t;

    pixel_exp_t       pixel_fifo[$];

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             colour_reg;
    pos_idx_t         row_pos;
    pos_idx_t         col_pos;
    group_phase_t     phase;
    byte_t            luma0;
    byte_t            chroma1;
    byte_t            luma1;
    logic             frame_open;

    function automatic byte_t q14_clamp(input int q);
        int v;
        v = q >>> 14;
        if (q < 0)
            return 8'h00;
        if (v > 255)
            return 8'hFF;
        return byte_t'(v);
    endfunction

    function automatic pos_idx_t side_last(input logic [CFG_W-1:0] v);
        int s;
        s = int'(v);
        if (s == 0)
            s = 1;
        else if (s > SIDE_MAX)
            s = SIDE_MAX;
        return pos_idx_t'(s - 1);
    endfunction

    // {red, green, blue}; first chroma drives blue, second drives red
    function automatic logic [23:0] yuv_to_rgb(input byte_t y, input byte_t c1,
                                               input byte_t c2);
        int yq;
        int d1;
        int d2;
        yq = int'(y) * 16384;
        d1 = int'(c1) - 128;
        d2 = int'(c2) - 128;
        return {q14_clamp(yq + COEF_R_C2 * d2),
                q14_clamp(yq - COEF_G_C2 * d2 - COEF_G_C1 * d1),
                q14_clamp(yq + COEF_B_C1 * d1)};
    endfunction

    task automatic queue_pixel(input logic [23:0] rgb, input logic last_flag,
                               output logic closed);
        pixel_exp_t p;
        pos_idx_t   wl;
        pos_idx_t   hl;
        wl     = side_last(width_reg);
        hl     = side_last(height_reg);
        closed = (row_pos >= hl) && (col_pos >= wl);
        p.red   = rgb[23:16];
        p.green = rgb[15:8];
        p.blue  = rgb[7:0];
        p.row   = row_pos;
        p.col   = col_pos;
        p.last  = last_flag | closed;
        p.done  = closed;
        pixel_fifo.push_back(p);
        if (closed)
        begin
            frame_open = 1'b0;
            frames_closed++;
        end
        else if (col_pos >= wl)
        begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic take_byte(input byte_t value, input logic start);
        logic closed;
        if (start)
        begin
            row_pos    = '0;
            col_pos    = '0;
            phase      = AWAIT_Y0;
            frame_open = 1'b1;
        end
        if (frame_open)
        begin
            if (!colour_reg)
            begin
                phase = AWAIT_Y0;
                queue_pixel({value, value, value}, 1'b1, closed);
            end
            else
            begin
                case (phase)
                    AWAIT_Y0:
                    begin
                        luma0 = value;
                        phase = AWAIT_C1;
                    end
                    AWAIT_C1:
                    begin
                        chroma1 = value;
                        phase   = AWAIT_Y1;
                    end
                    AWAIT_Y1:
                    begin
                        luma1 = value;
                        phase = AWAIT_C2;
                    end
                    default:
                    begin
                        phase = AWAIT_Y0;
                        queue_pixel(yuv_to_rgb(luma0, chroma1, value), 1'b0, closed);
                        if (!closed)
                            queue_pixel(yuv_to_rgb(luma1, chroma1, value), 1'b1, closed);
                    end
                endcase
            end
        end
    endtask

    task automatic check_field(input string name, input logic [11:0] expv,
                               input logic [11:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: pixel %s mismatch, expected %0d actual %0d",
                     $time, name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_exp_t want;
        if (!rst_n)
        begin
            pixel_fifo.delete();
            width_reg      = RESET_WIDTH;
            height_reg     = RESET_HEIGHT;
            colour_reg     = 1'b1;
            row_pos        = '0;
            col_pos        = '0;
            phase          = AWAIT_Y0;
            luma0          = '0;
            chroma1        = '0;
            luma1          = '0;
            frame_open     = 1'b0;
            fail_count     = 0;
            pixels_pending = 0;
            pixels_checked = 0;
            frames_closed  = 0;
        end
        else
        begin
            if (raster.valid && raster.ready)
            begin
                if (pixel_fifo.size() == 0)
                begin
                    $display("%0t: unexpected pixel, expected none actual row %0d col %0d",
                             $time, raster.pixel_row, raster.pixel_col);
                    fail_count++;
                end
                else
                begin
                    want = pixel_fifo.pop_front();
                    check_field("red", 12'(want.red), 12'(raster.red));
                    check_field("green", 12'(want.green), 12'(raster.green));
                    check_field("blue", 12'(want.blue), 12'(raster.blue));
                    check_field("row", want.row, raster.pixel_row);
                    check_field("col", want.col, raster.pixel_col);
                    check_field("last_of_run", 12'(want.last), 12'(raster.last_of_run));
                    check_field("frame_done", 12'(want.done), 12'(raster.frame_done));
                    pixels_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    CFG_COLOUR_MODE:  colour_reg = cfg_data[0];
                    default: ;
                endcase
            end
            if (camera.valid && camera.ready)
                take_byte(camera.component, camera.frame_start);
            pixels_pending = pixel_fifo.size();
        end
    end

endmodule

// File: bench/yuyv_stream_to_rgb_raster_top_tb.sv
// ============================================================================
// yuyv_stream_to_rgb_raster_top_tb
// Stimulus and verdict for the YUYV to RGB raster block.
// A short directed run covers reset settings, closed frames, clamping
// extremes, a pair cut at frame end and zero sizes; then random frames run
// over many sizes and both modes with random gaps on both channels.
// ============================================================================
module yuyv_stream_to_rgb_raster_top_tb;
    import yrgb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 750;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    yrgb_in_if  camera_if();
    yrgb_out_if raster_if();

    int unsigned fail_count;
    int unsigned pixels_pending;
    int unsigned pixels_checked;
    int unsigned frames_closed;

    int unsigned bytes_sent    = 0;
    int unsigned useful_bytes  = 0;
    int unsigned settings_used = 0;
    int unsigned idle_cycles   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          stall_left    = 0;

    logic [CFG_W-1:0] cur_w;
    logic [CFG_W-1:0] cur_h;
    logic             cur_mode;

    yuyv_stream_to_rgb_raster_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .camera    (camera_if),
        .raster    (raster_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    yuyv_stream_to_rgb_raster_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .camera         (camera_if),
        .raster         (raster_if),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pixels_pending (pixels_pending),
        .pixels_checked (pixels_checked),
        .frames_closed  (frames_closed)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic byte_t rand_component();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return byte_t'($urandom_range(0, 255));
    endfunction

    // raster back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            raster_if.ready <= 1'b0;
            stall_left--;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            raster_if.ready <= 1'b0;
            stall_left = pick_gap() - 1;
        end
        else
        begin
            raster_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((camera_if.valid && camera_if.ready) || (raster_if.valid && raster_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL yuyv_stream_to_rgb_raster_top");
                $finish;
            end
        end
    end

    task automatic send_byte(input byte_t value, input logic start);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = pick_gap();
        if (gap > 0)
        begin
            camera_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        camera_if.valid       <= 1'b1;
        camera_if.component   <= value;
        camera_if.frame_start <= start;
        do
            @(posedge clk);
        while (!camera_if.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_group(input byte_t y0, input byte_t c1, input byte_t y1,
                              input byte_t c2, input logic start);
        send_byte(y0, start);
        send_byte(c1, 1'b0);
        send_byte(y1, 1'b0);
        send_byte(c2, 1'b0);
    endtask

    // drain the block, then allow for bytes still in flight that make no pixel
    task automatic wait_drained(input int settle);
        camera_if.valid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic mode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= CFG_COLOUR_MODE;
        cfg_data  <= {{(CFG_W-1){1'b0}}, mode};
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_w     = w;
        cur_h     = h;
        cur_mode  = mode;
        settings_used++;
    endtask

    task automatic send_frame(input logic start);
        int   w;
        int   h;
        int   count;
        logic fs;
        w = (cur_w == 0) ? 1 : ((cur_w > SIDE_MAX) ? SIDE_MAX : int'(cur_w));
        h = (cur_h == 0) ? 1 : ((cur_h > SIDE_MAX) ? SIDE_MAX : int'(cur_h));
        count = cur_mode ? ((w * h + 1) / 2) * 4 : w * h;
        if (count > 48)
            count = $urandom_range(8, 48);
        if ($urandom_range(0, 9) == 0)
            count = $urandom_range(1, count);
        for (int i = 0; i < count; i++)
        begin
            fs = (i == 0) ? start : ($urandom_range(0, 59) == 0);
            send_byte(rand_component(), fs);
            useful_bytes++;
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5)) send_byte(rand_component(), 1'b0);
    endtask

    initial
    begin
        int               r;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_FRAME_WIDTH;
        cfg_data              = '0;
        camera_if.valid       = 1'b0;
        camera_if.component   = '0;
        camera_if.frame_start = 1'b0;
        raster_if.ready       = 1'b0;
        cur_w                 = RESET_WIDTH;
        cur_h                 = RESET_HEIGHT;
        cur_mode              = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: bytes before any frame start are dropped
        stall_pct     = 20;
        send_idle_pct = 20;
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_group(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1);
        send_group(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
        send_group(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);

        // odd pixel count: second pixel of the last pair is dropped
        wait_drained(6);
        write_config(13'd3, 13'd1, 1'b1);
        send_group(8'd16, 8'd200, 8'd235, 8'd40, 1'b1);
        send_group(8'd80, 8'd90, 8'd100, 8'd110, 1'b0);
        send_byte(8'd7, 1'b0);
        send_byte(8'd9, 1'b0);

        // zero sizes read as one, grey mode
        wait_drained(6);
        write_config(13'd0, 13'd0, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);

        while (useful_bytes < RANDOM_BYTES)
        begin
            wait_drained(6);
            r = $urandom_range(0, 19);
            case (r)
                0:       w = 13'd0;
                1:       w = 13'd4096;
                2:       w = CFG_W'($urandom_range(4097, 8191));
                3:       w = CFG_W'($urandom_range(0, 8191));
                default: w = CFG_W'($urandom_range(1, 6));
            endcase
            r = $urandom_range(0, 19);
            case (r)
                0:       h = 13'd0;
                1:       h = 13'd4096;
                2:       h = CFG_W'($urandom_range(4097, 8191));
                3:       h = CFG_W'($urandom_range(0, 8191));
                default: h = CFG_W'($urandom_range(1, 4));
            endcase
            write_config(w, h, 1'($urandom_range(0, 1)));
            r = $urandom_range(0, 3);
            stall_pct     = (r == 0) ? 0 : ((r == 1) ? 10 : ((r == 2) ? 30 : 60));
            r = $urandom_range(0, 3);
            send_idle_pct = (r == 0) ? 0 : ((r == 1) ? 10 : ((r == 2) ? 30 : 60));
            repeat ($urandom_range(1, 3))
                send_frame($urandom_range(0, 4) != 0);
        end

        wait_drained(20);
        $display("Run covered %0d camera bytes under %0d register settings in both modes.",
                 bytes_sent, settings_used);
        $display("Checked %0d pixels, %0d frames closed.", pixels_checked, frames_closed);
        if (fail_count == 0)
            $display("PASS yuyv_stream_to_rgb_raster_top");
        else
            $display("FAIL yuyv_stream_to_rgb_raster_top");
        $finish;
    end

endmodule

// File: sim.f
rtl/yrgb_pkg.sv
rtl/yrgb_if.sv
rtl/yuyv_stream_to_rgb_raster_top.sv
rtl/yrgb_checker.sv
bench/yuyv_stream_to_rgb_raster_checker.sv
bench/yuyv_stream_to_rgb_raster_top_tb.sv
